[hdl/gsc_pkg.sv]
// Shared types, constants and state encodings of the grid shading gain calibration unit.
package gsc_pkg;

  localparam int CFG_W      = 13;
  localparam int SAMPLE_W   = 8;
  localparam int SUM_W      = 40;
  localparam int NUM_CH     = 3;
  localparam int GAIN_W     = 16;
  // quotient bits below the Q8.8 point plus one guard bit for rounding
  localparam int FRAC_EXTRA = 9;
  // eight integer bits, the fraction bits and one overflow bit
  localparam int QUO_W      = 8 + FRAC_EXTRA + 1;

  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 13'd640;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 13'd480;
  localparam logic [CFG_W-1:0] CELL_WIDTH_RST   = 13'd80;
  localparam logic [CFG_W-1:0] CELL_HEIGHT_RST  = 13'd60;

  typedef enum logic [1:0] {
    REG_FRAME_WIDTH,
    REG_FRAME_HEIGHT,
    REG_CELL_WIDTH,
    REG_CELL_HEIGHT
  } cfg_reg_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] channel_zero;
    logic [SAMPLE_W-1:0] channel_one;
    logic [SAMPLE_W-1:0] channel_two;
  } pixel_t;

  typedef struct packed {
    logic [2:0]        cell_row;
    logic [2:0]        cell_col;
    logic [GAIN_W-1:0] gain_zero;
    logic [GAIN_W-1:0] gain_one;
    logic [GAIN_W-1:0] gain_two;
    logic              final_cell;
  } result_t;

  typedef logic [SUM_W-1:0] sum_t;
  typedef sum_t [NUM_CH-1:0] sum3_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RECALC,
    ST_FLUSH,
    ST_GEOM,
    ST_READ,
    ST_LOAD,
    ST_SPAN,
    ST_GSTART,
    ST_GWAIT,
    ST_EMIT,
    ST_CLEAR
  } ctrl_state_t;

  typedef enum logic [2:0] {
    GS_IDLE,
    GS_MUL,
    GS_PREP,
    GS_DIV,
    GS_DONE
  } gain_state_t;

endpackage

[hdl/gsc_accum.sv]
// Per-cell sum memory with read-modify-write pipeline, forwarding and whole-frame sums.
module gsc_accum #(
  parameter int NCELLS = 64,
  parameter int AW     = 6
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            acc_en,
  input  logic [AW-1:0]   acc_addr,
  input  gsc_pkg::pixel_t acc_pixel,
  input  logic            rd_en,
  input  logic [AW-1:0]   rd_addr,
  input  logic            clear,
  output gsc_pkg::sum3_t  cell_sum,
  output gsc_pkg::sum3_t  frame_sum
);

  gsc_pkg::sum3_t  mem [NCELLS];
  logic [NCELLS-1:0] written;

  gsc_pkg::sum3_t  mem_q;
  logic            mem_q_valid;
  logic [AW-1:0]   rd_a;

  logic            s1_valid;
  logic [AW-1:0]   s1_addr;
  gsc_pkg::pixel_t s1_pixel;

  logic            fw_valid;
  logic [AW-1:0]   fw_addr;
  gsc_pkg::sum3_t  fw_data;

  gsc_pkg::sum3_t  base;
  gsc_pkg::sum3_t  upd;

  // pixel reads win; emit reads only happen while no pixel is taken
  assign rd_a = acc_en ? acc_addr : rd_addr;

  // registered read port
  always_ff @(posedge clk) begin
    if (acc_en || rd_en) begin
      mem_q <= mem[rd_a];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mem_q_valid <= 1'b0;
    end else if (acc_en || rd_en) begin
      mem_q_valid <= written[rd_a];
    end
  end

  // stage 1: pixel waits for its read data
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= acc_en;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_en) begin
      s1_addr  <= acc_addr;
      s1_pixel <= acc_pixel;
    end
  end

  // bypass the write of the previous cycle, which the read missed
  always_comb begin
    if (fw_valid && (fw_addr == s1_addr)) begin
      base = fw_data;
    end else if (mem_q_valid) begin
      base = mem_q;
    end else begin
      base = '0;
    end
    upd[0] = base[0] + gsc_pkg::SUM_W'(s1_pixel.channel_zero);
    upd[1] = base[1] + gsc_pkg::SUM_W'(s1_pixel.channel_one);
    upd[2] = base[2] + gsc_pkg::SUM_W'(s1_pixel.channel_two);
  end

  // write back
  always_ff @(posedge clk) begin
    if (s1_valid) begin
      mem[s1_addr] <= upd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      written  <= '0;
      fw_valid <= 1'b0;
    end else begin
      fw_valid <= s1_valid;
      if (s1_valid) begin
        written[s1_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      fw_addr <= s1_addr;
      fw_data <= upd;
    end
  end

  // whole-frame sums
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      frame_sum <= '0;
    end else if (s1_valid) begin
      frame_sum[0] <= frame_sum[0] + gsc_pkg::SUM_W'(s1_pixel.channel_zero);
      frame_sum[1] <= frame_sum[1] + gsc_pkg::SUM_W'(s1_pixel.channel_one);
      frame_sum[2] <= frame_sum[2] + gsc_pkg::SUM_W'(s1_pixel.channel_two);
    end
  end

  // entries not written this frame read as zero
  assign cell_sum = mem_q_valid ? mem_q : '0;

endmodule

[hdl/gsc_gain.sv]
// Gain unit: shift-add products, then a bit-serial divide to a rounded, saturated Q8.8 gain.
module gsc_gain #(
  parameter int NW = 26
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  gsc_pkg::sum_t              frame_sum,
  input  gsc_pkg::sum_t              cell_sum,
  input  logic [NW-1:0]              cell_pix,
  input  logic [NW-1:0]              frame_pix,
  output logic                       done,
  output logic [gsc_pkg::GAIN_W-1:0] gain
);

  localparam int MW = gsc_pkg::SUM_W + NW;
  localparam int XW = MW + gsc_pkg::FRAC_EXTRA;
  localparam int CW = $clog2(XW + 1);
  localparam int QW = gsc_pkg::QUO_W;

  gsc_pkg::gain_state_t state, state_next;

  logic [CW-1:0] cnt;
  logic [MW-1:0] ma1, ma2, p1, p2;
  logic [NW-1:0] mb1, mb2;
  logic [MW-1:0] den, rem;
  logic [XW-1:0] dx;
  logic [QW-1:0] quo;
  logic          sat;

  logic          use_full;
  logic [MW:0]   trial;
  logic          ge;
  logic [QW-1:0] rnd;
  logic          ovf;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      gsc_pkg::GS_IDLE: if (start) state_next = gsc_pkg::GS_MUL;
      gsc_pkg::GS_MUL:  if (cnt == CW'(NW - 1)) state_next = gsc_pkg::GS_PREP;
      gsc_pkg::GS_PREP: state_next = gsc_pkg::GS_DIV;
      gsc_pkg::GS_DIV:  if (cnt == CW'(XW - 1)) state_next = gsc_pkg::GS_DONE;
      gsc_pkg::GS_DONE: state_next = gsc_pkg::GS_IDLE;
      default:          state_next = gsc_pkg::GS_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    unique case (state)
      gsc_pkg::GS_DONE: done = 1'b1;
      default:          done = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gsc_pkg::GS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // a cell holding fewer counts than pixels uses the frame mean alone
  assign use_full = (cell_pix != '0) && (MW'(cell_sum) >= MW'(cell_pix));

  // one restoring divide step
  assign trial = {rem, dx[XW-1]};
  assign ge    = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    unique case (state)
      gsc_pkg::GS_IDLE: begin
        cnt <= '0;
        ma1 <= MW'(frame_sum);
        mb1 <= cell_pix;
        ma2 <= MW'(cell_sum);
        mb2 <= frame_pix;
        p1  <= '0;
        p2  <= '0;
      end
      gsc_pkg::GS_MUL: begin
        p1  <= p1 + (mb1[0] ? ma1 : '0);
        p2  <= p2 + (mb2[0] ? ma2 : '0);
        ma1 <= ma1 << 1;
        ma2 <= ma2 << 1;
        mb1 <= mb1 >> 1;
        mb2 <= mb2 >> 1;
        cnt <= cnt + 1'b1;
      end
      gsc_pkg::GS_PREP: begin
        dx  <= {(use_full ? p1 : MW'(frame_sum)), gsc_pkg::FRAC_EXTRA'(0)};
        den <= use_full ? p2 : MW'(frame_pix);
        rem <= '0;
        quo <= '0;
        sat <= 1'b0;
        cnt <= '0;
      end
      gsc_pkg::GS_DIV: begin
        rem <= ge ? MW'(trial - {1'b0, den}) : trial[MW-1:0];
        dx  <= dx << 1;
        sat <= sat | quo[QW-1];
        quo <= {quo[QW-2:0], ge};
        cnt <= cnt + 1'b1;
      end
      default: begin
      end
    endcase
  end

  // round half up from the guard bit, saturate past 8 integer bits
  assign ovf = sat | quo[QW-1];
  assign rnd = QW'(quo[QW-2:0]) + QW'(1);

  always_comb begin
    if (ovf || rnd[QW-1]) begin
      gain = '1;
    end else begin
      gain = rnd[gsc_pkg::GAIN_W:1];
    end
  end

endmodule

[hdl/grid_shading_gain_calibration_unit.sv]
// Top level of the grid shading gain calibration unit: position tracking, control and emit.
// Usage:
//   Pixels enter on start/pixel in raster order, one per clock while busy is low; an item is
//   taken at a clock edge with start high and busy low. Each pixel is added to the frame sums
//   and to its grid cell's sums held in a 64-entry memory, read at the accept edge and written
//   back in the following cycle with a bypass when neighbors hit the same cell, so pixels
//   flow at one per cycle while busy is low.
//   After the frame's last pixel busy rises and one result per grid cell comes out in row-major
//   order, each on result for a single cycle with result_strobe high; final_cell marks the last.
//   Each channel's gain takes a start state, a shift-add multiply, a setup step, a bit-serial
//   divide and a done state. Sums clear at the end.
//   Registers are written on cfg_valid/cfg_ready with cfg_index and cfg_data; after a write the
//   block stays busy re-deriving the current pixel's grid cell.
//   Reset (rst, synchronous) restores the register defaults and clears all sums and positions.
//   The receiver cannot stall: results are not held.
module grid_shading_gain_calibration_unit #(
  parameter int CELLS_PER_AXIS = 8,
  parameter int MAX_FRAME_DIM  = 4096
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  gsc_pkg::pixel_t           pixel,
  output logic                      busy,
  output logic                      result_strobe,
  output gsc_pkg::result_t          result,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [1:0]                cfg_index,
  input  logic [gsc_pkg::CFG_W-1:0] cfg_data
);

  localparam int NCELLS = CELLS_PER_AXIS * CELLS_PER_AXIS;
  localparam int AW     = (NCELLS > 1) ? $clog2(NCELLS) : 1;
  localparam int CIW    = (CELLS_PER_AXIS > 1) ? $clog2(CELLS_PER_AXIS) : 1;
  localparam int PW     = $clog2(MAX_FRAME_DIM);
  localparam int DW     = (PW + 1 > gsc_pkg::CFG_W) ? PW + 1 : gsc_pkg::CFG_W;
  localparam int NW     = 2 * DW;
  localparam int RCW    = $clog2(PW + 1);
  localparam int LW     = DW + CIW;

  gsc_pkg::ctrl_state_t state, state_next;

  // configuration registers
  logic [gsc_pkg::CFG_W-1:0] frame_width, frame_height, cell_width, cell_height;
  logic [DW-1:0] w_e, h_e, cw_e, ch_e;

  // pixel position and its grid cell
  logic [PW-1:0]  col, row, col_off, row_off;
  logic [CIW-1:0] cj, ci;

  // cell re-derivation after a register write
  logic [RCW-1:0] rc_cnt;
  logic [PW-1:0]  rc_cx, rc_rx, rc_cq, rc_rq;
  logic [DW-1:0]  rc_cr, rc_rr;
  logic [DW-1:0]  rc_ct, rc_rt;
  logic           rc_cge, rc_rge;
  logic [DW-1:0]  rc_cr_next, rc_rr_next;
  logic [PW-1:0]  rc_cq_next, rc_rq_next;

  // emit datapath
  logic [CIW:0]          ncol, nrow, ncol_c, nrow_c;
  logic [NW-1:0]         pix, cell_n;
  logic [CIW-1:0]        ei, ej;
  logic [DW-1:0]         span_r, span_c;
  gsc_pkg::sum3_t        cell_sum_q;
  logic [1:0]            ch;
  logic [gsc_pkg::GAIN_W-1:0] gain_q [gsc_pkg::NUM_CH];
  logic                  last_cell, last_col;

  logic           accept, cfg_wr, frame_end;
  logic           col_last, row_last, col_off_last, row_off_last;
  logic [AW-1:0]  acc_addr, rd_addr;
  logic           rd_en, gain_start, acc_clear, gain_done;
  gsc_pkg::sum3_t cell_sum, frame_sum;
  logic [gsc_pkg::GAIN_W-1:0] gain;

  // zero acts as one, oversize clamps to the largest frame
  function automatic logic [DW-1:0] eff(input logic [gsc_pkg::CFG_W-1:0] v);
    logic [DW-1:0] x;
    x = DW'(v);
    if (v == '0) begin
      eff = DW'(1);
    end else if (x > DW'(MAX_FRAME_DIM)) begin
      eff = DW'(MAX_FRAME_DIM);
    end else begin
      eff = x;
    end
  endfunction

  // extent of cell k on an axis of cnt cells; the last one runs to the frame edge
  function automatic logic [DW-1:0] span(input logic [CIW-1:0] k, input logic [CIW:0] cnt,
                                         input logic [DW-1:0] size, input logic [DW-1:0] csz);
    logic [LW-1:0] lo, hi;
    lo = LW'(k) * LW'(csz);
    if ((CIW+1)'(k) + (CIW+1)'(1) == cnt) begin
      hi = LW'(size);
    end else begin
      hi = lo + LW'(csz);
    end
    if (hi > LW'(size)) begin
      hi = LW'(size);
    end
    span = (hi > lo) ? DW'(hi - lo) : '0;
  endfunction

  assign w_e  = eff(frame_width);
  assign h_e  = eff(frame_height);
  assign cw_e = eff(cell_width);
  assign ch_e = eff(cell_height);

  assign accept = start && !busy;
  assign cfg_wr = cfg_valid && cfg_ready;

  assign col_last     = (DW'(col) + DW'(1)) >= w_e;
  assign row_last     = (DW'(row) + DW'(1)) >= h_e;
  assign col_off_last = (DW'(col_off) + DW'(1)) >= cw_e;
  assign row_off_last = (DW'(row_off) + DW'(1)) >= ch_e;
  assign frame_end    = accept && col_last && row_last;

  assign acc_addr = AW'(ci) * AW'(CELLS_PER_AXIS) + AW'(cj);
  assign rd_addr  = AW'(ei) * AW'(CELLS_PER_AXIS) + AW'(ej);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= gsc_pkg::FRAME_WIDTH_RST;
      frame_height <= gsc_pkg::FRAME_HEIGHT_RST;
      cell_width   <= gsc_pkg::CELL_WIDTH_RST;
      cell_height  <= gsc_pkg::CELL_HEIGHT_RST;
    end else if (cfg_wr) begin
      unique case (gsc_pkg::cfg_reg_t'(cfg_index))
        gsc_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        gsc_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data;
        gsc_pkg::REG_CELL_WIDTH:   cell_width   <= cfg_data;
        gsc_pkg::REG_CELL_HEIGHT:  cell_height  <= cfg_data;
      endcase
    end
  end

  // restoring divide step for column / cell_width and row / cell_height
  always_comb begin
    rc_ct      = {rc_cr[DW-2:0], rc_cx[PW-1]};
    rc_rt      = {rc_rr[DW-2:0], rc_rx[PW-1]};
    rc_cge     = rc_ct >= cw_e;
    rc_rge     = rc_rt >= ch_e;
    rc_cr_next = rc_cge ? rc_ct - cw_e : rc_ct;
    rc_rr_next = rc_rge ? rc_rt - ch_e : rc_rt;
    rc_cq_next = {rc_cq[PW-2:0], rc_cge};
    rc_rq_next = {rc_rq[PW-2:0], rc_rge};
  end

  always_ff @(posedge clk) begin
    if (cfg_wr) begin
      rc_cnt <= '0;
      rc_cx  <= col;
      rc_rx  <= row;
      rc_cr  <= '0;
      rc_rr  <= '0;
      rc_cq  <= '0;
      rc_rq  <= '0;
    end else if (state == gsc_pkg::ST_RECALC) begin
      rc_cnt <= rc_cnt + 1'b1;
      rc_cx  <= rc_cx << 1;
      rc_rx  <= rc_rx << 1;
      rc_cr  <= rc_cr_next;
      rc_rr  <= rc_rr_next;
      rc_cq  <= rc_cq_next;
      rc_rq  <= rc_rq_next;
    end
  end

  // pixel position and cell tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      col     <= '0;
      row     <= '0;
      col_off <= '0;
      row_off <= '0;
      cj      <= '0;
      ci      <= '0;
    end else if ((state == gsc_pkg::ST_RECALC) && (rc_cnt == RCW'(PW - 1))) begin
      col_off <= rc_cr_next[PW-1:0];
      row_off <= rc_rr_next[PW-1:0];
      cj <= (rc_cq_next >= PW'(CELLS_PER_AXIS - 1)) ? CIW'(CELLS_PER_AXIS - 1)
                                                    : rc_cq_next[CIW-1:0];
      ci <= (rc_rq_next >= PW'(CELLS_PER_AXIS - 1)) ? CIW'(CELLS_PER_AXIS - 1)
                                                    : rc_rq_next[CIW-1:0];
    end else if (accept) begin
      if (col_last) begin
        col     <= '0;
        col_off <= '0;
        cj      <= '0;
        if (row_last) begin
          row     <= '0;
          row_off <= '0;
          ci      <= '0;
        end else begin
          row <= row + 1'b1;
          if (row_off_last) begin
            row_off <= '0;
            if (ci != CIW'(CELLS_PER_AXIS - 1)) ci <= ci + 1'b1;
          end else begin
            row_off <= row_off + 1'b1;
          end
        end
      end else begin
        col <= col + 1'b1;
        if (col_off_last) begin
          col_off <= '0;
          if (cj != CIW'(CELLS_PER_AXIS - 1)) cj <= cj + 1'b1;
        end else begin
          col_off <= col_off + 1'b1;
        end
      end
    end
  end

  // grid size: count the cell starts that fall inside the frame
  always_comb begin
    ncol_c = (CIW+1)'(1);
    nrow_c = (CIW+1)'(1);
    for (int k = 1; k < CELLS_PER_AXIS; k++) begin
      if (LW'(k) * LW'(cw_e) < LW'(w_e)) ncol_c = ncol_c + 1'b1;
      if (LW'(k) * LW'(ch_e) < LW'(h_e)) nrow_c = nrow_c + 1'b1;
    end
  end

  assign last_col  = (CIW+1)'(ej) + (CIW+1)'(1) == ncol;
  assign last_cell = last_col && ((CIW+1)'(ei) + (CIW+1)'(1) == nrow);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      gsc_pkg::ST_IDLE: begin
        if (frame_end) begin
          state_next = gsc_pkg::ST_FLUSH;
        end else if (cfg_wr) begin
          state_next = gsc_pkg::ST_RECALC;
        end
      end
      gsc_pkg::ST_RECALC: if (rc_cnt == RCW'(PW - 1)) state_next = gsc_pkg::ST_IDLE;
      gsc_pkg::ST_FLUSH:  state_next = gsc_pkg::ST_GEOM;
      gsc_pkg::ST_GEOM:   state_next = gsc_pkg::ST_READ;
      gsc_pkg::ST_READ:   state_next = gsc_pkg::ST_LOAD;
      gsc_pkg::ST_LOAD:   state_next = gsc_pkg::ST_SPAN;
      gsc_pkg::ST_SPAN:   state_next = gsc_pkg::ST_GSTART;
      gsc_pkg::ST_GSTART: state_next = gsc_pkg::ST_GWAIT;
      gsc_pkg::ST_GWAIT: begin
        if (gain_done) begin
          state_next = (ch == 2'd2) ? gsc_pkg::ST_EMIT : gsc_pkg::ST_GSTART;
        end
      end
      gsc_pkg::ST_EMIT:   state_next = last_cell ? gsc_pkg::ST_CLEAR : gsc_pkg::ST_READ;
      gsc_pkg::ST_CLEAR:  state_next = gsc_pkg::ST_IDLE;
      default:            state_next = gsc_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    busy          = 1'b1;
    cfg_ready     = 1'b0;
    result_strobe = 1'b0;
    rd_en         = 1'b0;
    gain_start    = 1'b0;
    acc_clear     = 1'b0;
    unique case (state)
      gsc_pkg::ST_IDLE: begin
        busy      = 1'b0;
        cfg_ready = 1'b1;
      end
      gsc_pkg::ST_READ:   rd_en = 1'b1;
      gsc_pkg::ST_GSTART: gain_start = 1'b1;
      gsc_pkg::ST_EMIT:   result_strobe = 1'b1;
      gsc_pkg::ST_CLEAR:  acc_clear = 1'b1;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gsc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // emit datapath
  always_ff @(posedge clk) begin
    unique case (state)
      gsc_pkg::ST_GEOM: begin
        ncol <= ncol_c;
        nrow <= nrow_c;
        pix  <= NW'(w_e) * NW'(h_e);
        ei   <= '0;
        ej   <= '0;
      end
      gsc_pkg::ST_LOAD: begin
        cell_sum_q <= cell_sum;
        span_r     <= span(ei, nrow, h_e, ch_e);
        span_c     <= span(ej, ncol, w_e, cw_e);
      end
      gsc_pkg::ST_SPAN: begin
        cell_n <= NW'(span_r) * NW'(span_c);
        ch     <= '0;
      end
      gsc_pkg::ST_GWAIT: begin
        if (gain_done) begin
          gain_q[ch] <= gain;
          ch         <= ch + 1'b1;
        end
      end
      gsc_pkg::ST_EMIT: begin
        if (last_col) begin
          ej <= '0;
          ei <= ei + 1'b1;
        end else begin
          ej <= ej + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign result.cell_row   = 3'(ei);
  assign result.cell_col   = 3'(ej);
  assign result.gain_zero  = gain_q[0];
  assign result.gain_one   = gain_q[1];
  assign result.gain_two   = gain_q[2];
  assign result.final_cell = last_cell;

  gsc_accum #(
    .NCELLS (NCELLS),
    .AW     (AW)
  ) u_accum (
    .clk       (clk),
    .rst       (rst),
    .acc_en    (accept),
    .acc_addr  (acc_addr),
    .acc_pixel (pixel),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .clear     (acc_clear),
    .cell_sum  (cell_sum),
    .frame_sum (frame_sum)
  );

  gsc_gain #(
    .NW (NW)
  ) u_gain (
    .clk       (clk),
    .rst       (rst),
    .start     (gain_start),
    .frame_sum (frame_sum[ch]),
    .cell_sum  (cell_sum_q[ch]),
    .cell_pix  (cell_n),
    .frame_pix (pix),
    .done      (gain_done),
    .gain      (gain)
  );

endmodule

[hdl/gsc_checker.sv]
// Port-level checks of the grid shading gain calibration unit, bound to the top level.
module gsc_checker (
  input logic             clk,
  input logic             rst,
  input logic             busy,
  input logic             result_strobe,
  input gsc_pkg::result_t result,
  input logic             cfg_valid,
  input logic             cfg_ready
);

  // results only come out during the emit phase
  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> busy)
    else $error("result strobe while not busy");

  // every result stands alone for a single cycle
  a_strobe_single: assert property (@(posedge clk) disable iff (rst)
    result_strobe |=> !result_strobe)
    else $error("back-to-back result strobes");

  // the block frees up after the clear state that follows the last cell of a frame
  a_final_release: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && result.final_cell) |-> ##2 !busy)
    else $error("block still busy after final cell");

  // a register write makes the block re-derive its position
  a_cfg_busy: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready) |=> busy)
    else $error("not busy after register write");

endmodule

bind grid_shading_gain_calibration_unit gsc_checker u_gsc_checker (
  .clk           (clk),
  .rst           (rst),
  .busy          (busy),
  .result_strobe (result_strobe),
  .result        (result),
  .cfg_valid     (cfg_valid),
  .cfg_ready     (cfg_ready)
);

[verif/gsc_checker.sv]
// Checker for the grid shading gain calibration unit: tracks items, predicts gains, compares results.
`timescale 1ns / 100ps
module gsc_tb_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  gsc_pkg::pixel_t           pixel,
  input  logic                      busy,
  input  logic                      result_strobe,
  input  gsc_pkg::result_t          result,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [1:0]                cfg_index,
  input  logic [gsc_pkg::CFG_W-1:0] cfg_data,
  output int                        errors,
  output int                        pending
);

  localparam int GRID    = 8;
  localparam int MAX_DIM = 4096;

  // shadow registers and accumulation state
  logic [gsc_pkg::CFG_W-1:0] frame_w, frame_h, cell_w, cell_h;
  int                        pos_col, pos_row;
  gsc_pkg::sum_t             frame_sum [gsc_pkg::NUM_CH];
  gsc_pkg::sum_t             cell_sum  [GRID*GRID][gsc_pkg::NUM_CH];
  gsc_pkg::result_t          gain_queue[$];

  assign pending = gain_queue.size();

  function automatic int eff_dim(logic [gsc_pkg::CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return int'(v);
  endfunction

  function automatic int axis_cells(int size, int cell_sz);
    int n;
    n = (size + cell_sz - 1) / cell_sz;
    return (n > GRID) ? GRID : n;
  endfunction

  // pixel extent of cell k on an axis; last cell takes the remainder
  function automatic int cell_extent(int k, int count, int size, int cell_sz);
    int lo, hi;
    lo = k * cell_sz;
    hi = (k + 1 == count) ? size : lo + cell_sz;
    if (hi > size) hi = size;
    return (hi > lo) ? hi - lo : 0;
  endfunction

  // round-half-up of 256*num/den in Q8.8, saturating
  function automatic logic [gsc_pkg::GAIN_W-1:0] q88_gain(logic [127:0] num,
                                                          logic [127:0] den);
    logic [127:0] q, r, v;
    q = num / den;
    r = num % den;
    if (q > 255) return '1;
    v = q;
    for (int i = 0; i < gsc_pkg::FRAC_EXTRA; i++) begin
      r = r << 1;
      v = v << 1;
      if (r >= den) begin
        r = r - den;
        v[0] = 1'b1;
      end
    end
    v = (v + 1) >> 1;
    return (v > 65535) ? 16'hFFFF : v[gsc_pkg::GAIN_W-1:0];
  endfunction

  function automatic void clear_frame();
    pos_col = 0;
    pos_row = 0;
    for (int c = 0; c < gsc_pkg::NUM_CH; c++) begin
      frame_sum[c] = '0;
      for (int k = 0; k < GRID*GRID; k++) cell_sum[k][c] = '0;
    end
  endfunction

  // one result per grid cell at frame end
  function automatic void predict_gains();
    int                         w, h, cw, ch, ncol, nrow;
    logic [127:0]               npix, pix, f, s;
    gsc_pkg::result_t           r;
    logic [gsc_pkg::GAIN_W-1:0] g [gsc_pkg::NUM_CH];
    w = eff_dim(frame_w); h = eff_dim(frame_h);
    cw = eff_dim(cell_w); ch = eff_dim(cell_h);
    ncol = axis_cells(w, cw);
    nrow = axis_cells(h, ch);
    pix = 128'(w) * 128'(h);
    for (int i = 0; i < nrow; i++) begin
      for (int j = 0; j < ncol; j++) begin
        npix = 128'(cell_extent(i, nrow, h, ch)) * 128'(cell_extent(j, ncol, w, cw));
        for (int c = 0; c < gsc_pkg::NUM_CH; c++) begin
          f = 128'(frame_sum[c]);
          s = 128'(cell_sum[i*GRID + j][c]);
          if (npix == 0 || s < npix) g[c] = q88_gain(f, pix);
          else                       g[c] = q88_gain(f * npix, pix * s);
        end
        r.cell_row   = i[2:0];
        r.cell_col   = j[2:0];
        r.gain_zero  = g[0];
        r.gain_one   = g[1];
        r.gain_two   = g[2];
        r.final_cell = (i + 1 == nrow) && (j + 1 == ncol);
        gain_queue.push_back(r);
      end
    end
  endfunction

  function automatic void accumulate(gsc_pkg::pixel_t p);
    int ci, cj, cell_idx, w, h;
    logic [gsc_pkg::SAMPLE_W-1:0] smp [gsc_pkg::NUM_CH];
    w = eff_dim(frame_w);
    h = eff_dim(frame_h);
    ci = pos_row / eff_dim(cell_h);
    cj = pos_col / eff_dim(cell_w);
    if (ci > GRID - 1) ci = GRID - 1;
    if (cj > GRID - 1) cj = GRID - 1;
    cell_idx = ci * GRID + cj;
    smp[0] = p.channel_zero;
    smp[1] = p.channel_one;
    smp[2] = p.channel_two;
    for (int c = 0; c < gsc_pkg::NUM_CH; c++) begin
      frame_sum[c]          = frame_sum[c] + gsc_pkg::SUM_W'(smp[c]);
      cell_sum[cell_idx][c] = cell_sum[cell_idx][c] + gsc_pkg::SUM_W'(smp[c]);
    end
    // sizes may shrink mid-frame, hence >=
    if (pos_col + 1 >= w) begin
      pos_col = 0;
      if (pos_row + 1 >= h) begin
        predict_gains();
        clear_frame();
      end else begin
        pos_row++;
      end
    end else begin
      pos_col++;
    end
  endfunction

  always @(posedge clk) begin
    gsc_pkg::result_t want;
    if (rst) begin
      frame_w = gsc_pkg::FRAME_WIDTH_RST;
      frame_h = gsc_pkg::FRAME_HEIGHT_RST;
      cell_w  = gsc_pkg::CELL_WIDTH_RST;
      cell_h  = gsc_pkg::CELL_HEIGHT_RST;
      clear_frame();
      gain_queue.delete();
      errors = 0;
    end else begin
      // register writes
      if (cfg_valid && cfg_ready) begin
        case (gsc_pkg::cfg_reg_t'(cfg_index))
          gsc_pkg::REG_FRAME_WIDTH:  frame_w = cfg_data;
          gsc_pkg::REG_FRAME_HEIGHT: frame_h = cfg_data;
          gsc_pkg::REG_CELL_WIDTH:   cell_w  = cfg_data;
          gsc_pkg::REG_CELL_HEIGHT:  cell_h  = cfg_data;
        endcase
      end
      // compare before accumulating so a new frame end cannot jump the queue
      if (result_strobe) begin
        if (gain_queue.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: unexpected result row %0d col %0d", $realtime,
                     result.cell_row, result.cell_col);
        end else begin
          want = gain_queue.pop_front();
          if (result.cell_row !== want.cell_row || result.cell_col !== want.cell_col ||
              result.gain_zero !== want.gain_zero || result.gain_one !== want.gain_one ||
              result.gain_two !== want.gain_two || result.final_cell !== want.final_cell) begin
            errors++;
            if (errors <= 10)
              $display("%0t: mismatch exp r%0d c%0d g %h %h %h f%b, got r%0d c%0d g %h %h %h f%b",
                       $realtime, want.cell_row, want.cell_col, want.gain_zero,
                       want.gain_one, want.gain_two, want.final_cell, result.cell_row,
                       result.cell_col, result.gain_zero, result.gain_one,
                       result.gain_two, result.final_cell);
          end
        end
      end
      if (start && !busy) accumulate(pixel);
    end
  end

endmodule

[verif/tb.sv]
// Testbench top for the grid shading gain calibration unit: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module tb;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      start = 1'b0;
  gsc_pkg::pixel_t           pixel = '0;
  logic                      busy, result_strobe, cfg_ready;
  gsc_pkg::result_t          result;
  logic                      cfg_valid = 1'b0;
  logic [1:0]                cfg_index = '0;
  logic [gsc_pkg::CFG_W-1:0] cfg_data = '0;
  int                        errors, pending;
  int                        items_sent = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  grid_shading_gain_calibration_unit u_top (
    .clk(clk), .rst(rst), .start(start), .pixel(pixel), .busy(busy),
    .result_strobe(result_strobe), .result(result), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  gsc_tb_checker u_chk (
    .clk(clk), .rst(rst), .start(start), .pixel(pixel), .busy(busy),
    .result_strobe(result_strobe), .result(result), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  // register write once the grid results have drained
  task automatic write_reg(gsc_pkg::cfg_reg_t idx, int val);
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[gsc_pkg::CFG_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_geometry(int w, int h, int cw, int ch);
    write_reg(gsc_pkg::REG_FRAME_WIDTH, w);
    write_reg(gsc_pkg::REG_FRAME_HEIGHT, h);
    write_reg(gsc_pkg::REG_CELL_WIDTH, cw);
    write_reg(gsc_pkg::REG_CELL_HEIGHT, ch);
  endtask

  // one pixel item with a random lead-in gap; start stays high for back-to-back items
  task automatic send_pixel(logic [7:0] c0, logic [7:0] c1, logic [7:0] c2);
    int gap;
    gap = $urandom_range(0, 3);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    pixel <= '{channel_zero: c0, channel_one: c1, channel_two: c2};
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  task automatic send_random();
    send_pixel($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
  endtask

  function automatic int pick_dim(int hi);
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return 8191;
      default: return $urandom_range(1, hi);
    endcase
  endfunction

  initial begin
    int w, h, cw, ch, npix;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // small frame, last cell column narrower, channel extremes
    set_geometry(3, 2, 2, 1);
    send_pixel(8'h00, 8'hFF, 8'h00);
    send_pixel(8'hFF, 8'h00, 8'hFF);
    send_pixel(8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'h55, 8'hAA, 8'h01);
    send_pixel(8'hAA, 8'h55, 8'h80);
    // columns clamp into the last cell, dark cells, zero cell, cell height of zero
    set_geometry(10, 1, 1, 0);
    send_pixel(8'h01, 8'h00, 8'h01);
    send_pixel(8'h00, 8'h01, 8'h00);
    repeat (8) send_pixel(8'hFF, 8'hFF, 8'hFF);
    // oversized registers, then the frame is cut short by smaller sizes
    set_geometry(8191, 8191, 8191, 4096);
    repeat (3) send_random();
    write_reg(gsc_pkg::REG_FRAME_WIDTH, 2);
    write_reg(gsc_pkg::REG_FRAME_HEIGHT, 1);
    send_random();

    // random geometries, mostly whole frames
    while (items_sent < 175) begin
      w  = pick_dim(12);
      h  = pick_dim(10);
      cw = pick_dim(4);
      ch = pick_dim(4);
      set_geometry(w, h, cw, ch);
      npix = (w == 0 ? 1 : (w > 4096 ? 4096 : w)) * (h == 0 ? 1 : (h > 4096 ? 4096 : h));
      if (items_sent + npix > 185 || $urandom_range(0, 7) == 0) begin
        // partial frame, then shrink so it finishes soon
        repeat ($urandom_range(1, 6)) send_random();
        write_reg(gsc_pkg::REG_FRAME_WIDTH, $urandom_range(1, 3));
        write_reg(gsc_pkg::REG_FRAME_HEIGHT, 1);
        send_random();
      end else begin
        repeat (npix) send_random();
      end
    end
    start <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // watchdog
  initial begin
    #200ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

[sim.f]
hdl/gsc_pkg.sv
hdl/gsc_accum.sv
hdl/gsc_gain.sv
hdl/grid_shading_gain_calibration_unit.sv
hdl/gsc_checker.sv
verif/gsc_checker.sv
verif/tb.sv
